// ===== src/block_max_range_query_defines.svh =====
// Assertion macros for the block max range query block.
`ifndef BLOCK_MAX_RANGE_QUERY_DEFINES_SVH
`define BLOCK_MAX_RANGE_QUERY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define BMRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bmrq assertion failed");

// Next-cycle implication, disabled during reset.
`define BMRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bmrq assertion failed");

`else

`define BMRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BMRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/bmrq_pkg.sv =====
// Shared constants, types and controller/datapath signal groups.
package bmrq_pkg;

    localparam int DEPTH  = 1024;
    localparam int BLOCK  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OFF_W  = $clog2(BLOCK);
    localparam int BLK_W  = IDX_W - OFF_W;
    localparam int NBLK   = DEPTH / BLOCK;

    localparam int LEN_W  = 11;
    localparam int VAL_W  = 48;
    localparam int AMT_W  = 32;
    localparam int OP_W   = 2;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [OP_W-1:0]   OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0]   OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0]   OP_QUERY = 2'd2;

    localparam logic [APB_AW-1:0] REG_USED_LENGTH = 2'd0;
    localparam logic [LEN_W-1:0]  USED_LENGTH_RST = 11'd1024;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [BLK_W-1:0] t_blk;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture transaction, set up pointers
        logic rd;        // read element at pointer
        logic ptr_inc;   // advance element pointer
        logic seg2;      // jump pointer to the tail partial block
        logic blk_step;  // fold one block max, advance block pointer
        logic wr;        // write updated element, raise block max
        logic clr;       // write zero at pointer (clearing pass)
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic is_query;
        logic same_blk;
        logic has_mid;
        logic ptr_at_end;
        logic ptr_last;
        logic blk_at_end;
        logic out_free;
    } t_sts;

endpackage

// ===== src/bmrq_ifs.sv =====
// Request and response channel interfaces.
interface bmrq_req_if;
    import bmrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [LEN_W-1:0]    first_index;
    logic [LEN_W-1:0]    last_index;
    logic [AMT_W-1:0]    amount;

    modport source (output valid, output opcode, output first_index, output last_index,
                    output amount, input ready);
    modport sink   (input valid, input opcode, input first_index, input last_index,
                    input amount, output ready);
endinterface

interface bmrq_rsp_if;
    import bmrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    range_max;
    logic                status;

    modport source (output valid, output range_max, output status, input ready);
    modport sink   (input valid, input range_max, input status, output ready);
endinterface

// ===== src/bmrq_dpath.sv =====
// Datapath: element memory, block maxima, pointers, running max, output register.
module bmrq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmrq_pkg::t_cmd                i_cmd,
    output bmrq_pkg::t_sts                o_sts,
    input  logic [bmrq_pkg::LEN_W-1:0]    i_used_length,
    input  logic [bmrq_pkg::OP_W-1:0]     i_opcode,
    input  logic [bmrq_pkg::LEN_W-1:0]    i_first_index,
    input  logic [bmrq_pkg::LEN_W-1:0]    i_last_index,
    input  logic [bmrq_pkg::AMT_W-1:0]    i_amount,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bmrq_pkg::VAL_W-1:0]    o_range_max,
    output logic                          o_status
);
    import bmrq_pkg::*;

    `include "block_max_range_query_defines.svh"

    t_val               mem [DEPTH];
    t_val               r_bmax [NBLK];

    logic [OP_W-1:0]    r_op;
    logic [LEN_W-1:0]   r_first;
    logic [LEN_W-1:0]   r_last;
    logic [AMT_W-1:0]   r_amt;
    t_idx               r_ptr;
    t_idx               r_end;
    t_blk               r_blk;
    t_val               r_rdata;
    logic               r_rd_vld;
    t_val               r_best;
    t_val               n_best;
    logic               r_out_vld;
    t_val               r_out_max;
    logic               r_out_status;

    logic [LEN_W-1:0]   lim;
    logic [LEN_W-1:0]   s_full, t_full, in_s_full, in_t_full;
    t_idx               s_idx, t_idx_l, in_s, in_t;
    t_blk               bs, bt, in_bs, in_bt;
    logic [VAL_W:0]     sum;
    t_val               upd;
    t_val               bmax_rd;
    t_val               bmax_wr;
    logic               op_ok;

    // range check on the captured transaction
    assign lim       = (i_used_length > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : i_used_length;
    assign s_full    = r_first - LEN_W'(1);
    assign t_full    = r_last - LEN_W'(1);
    assign s_idx     = s_full[IDX_W-1:0];
    assign t_idx_l   = t_full[IDX_W-1:0];
    assign bs        = s_idx[IDX_W-1:OFF_W];
    assign bt        = t_idx_l[IDX_W-1:OFF_W];

    assign in_s_full = i_first_index - LEN_W'(1);
    assign in_t_full = i_last_index - LEN_W'(1);
    assign in_s      = in_s_full[IDX_W-1:0];
    assign in_t      = in_t_full[IDX_W-1:0];
    assign in_bs     = in_s[IDX_W-1:OFF_W];
    assign in_bt     = in_t[IDX_W-1:OFF_W];

    assign op_ok = (r_op == OP_LOAD) || (r_op == OP_ADD) || (r_op == OP_QUERY);

    always_comb begin
        o_sts.err = !op_ok || (r_first == '0) || (r_first > lim) ||
                    ((r_op == OP_QUERY) &&
                     ((r_last == '0) || (r_last > lim) || (r_first > r_last)));
        o_sts.is_query   = (r_op == OP_QUERY);
        o_sts.same_blk   = (bs == bt);
        o_sts.has_mid    = {1'b0, bt} > ({1'b0, bs} + (BLK_W+1)'(1));
        o_sts.ptr_at_end = (r_ptr == r_end);
        o_sts.ptr_last   = (r_ptr == IDX_W'(DEPTH - 1));
        o_sts.blk_at_end = (r_blk == (bt - BLK_W'(1)));
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // load value or saturating add
    assign sum     = {1'b0, r_rdata} + (VAL_W+1)'(r_amt);
    assign upd     = (r_op == OP_LOAD) ? VAL_W'(r_amt) :
                     (sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0]);
    assign bmax_rd = r_bmax[r_blk];
    assign bmax_wr = r_bmax[r_ptr[IDX_W-1:OFF_W]];

    always_comb begin
        n_best = r_best;
        if (r_rd_vld && (r_rdata > n_best)) begin
            n_best = r_rdata;
        end
        if (i_cmd.blk_step && (bmax_rd > n_best)) begin
            n_best = bmax_rd;
        end
    end

    // single-port element memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_ptr] <= '0;
        end else if (i_cmd.wr) begin
            mem[r_ptr] <= upd;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBLK; b++) begin
                r_bmax[b] <= '0;
            end
        end else if (i_cmd.wr && (upd > bmax_wr)) begin
            r_bmax[r_ptr[IDX_W-1:OFF_W]] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_first <= i_first_index;
            r_last  <= i_last_index;
            r_amt   <= i_amount;
            r_end   <= (in_bs == in_bt) ? in_t : {in_bs, {OFF_W{1'b1}}};
            r_blk   <= in_bs + BLK_W'(1);
        end else begin
            if (i_cmd.seg2) begin
                r_end <= t_idx_l;
            end
            if (i_cmd.blk_step) begin
                r_blk <= r_blk + BLK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_ptr <= in_s;
            end else if (i_cmd.seg2) begin
                r_ptr <= {bt, {OFF_W{1'b0}}};
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_best <= '0;
        end else if (i_cmd.wr) begin
            r_best <= upd;
        end else begin
            r_best <= n_best;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_max    <= r_best;
            r_out_status <= o_sts.err;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_range_max = r_out_max;
    assign o_status    = r_out_status;

    `BMRQ_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_cmd.out_load && o_sts.err, r_best == '0)
    `BMRQ_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, i_cmd.ptr_inc && !i_cmd.clr, r_ptr != r_end)

endmodule

// ===== src/bmrq_ctrl.sv =====
// Controller: sequences clearing, update and query scans.
module bmrq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bmrq_pkg::t_sts  i_sts,
    output bmrq_pkg::t_cmd  o_cmd
);
    import bmrq_pkg::*;

    `include "block_max_range_query_defines.svh"

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_RMW_RD = 4'd3;
    localparam logic [3:0] S_RMW_WR = 4'd4;
    localparam logic [3:0] S_SCAN1  = 4'd5;
    localparam logic [3:0] S_SCAN2  = 4'd6;
    localparam logic [3:0] S_SCAN3  = 4'd7;
    localparam logic [3:0] S_DRAIN  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr     = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.is_query) begin
                    n_state = S_SCAN1;
                end else begin
                    n_state = S_RMW_RD;
                end
            end
            S_RMW_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DONE;
            end
            S_SCAN1: begin
                o_cmd.rd = 1'b1;
                if (!i_sts.ptr_at_end) begin
                    o_cmd.ptr_inc = 1'b1;
                end else if (i_sts.same_blk) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.seg2 = 1'b1;
                    n_state    = S_SCAN2;
                end
            end
            S_SCAN2: begin
                o_cmd.rd = 1'b1;
                if (!i_sts.ptr_at_end) begin
                    o_cmd.ptr_inc = 1'b1;
                end else if (i_sts.has_mid) begin
                    n_state = S_SCAN3;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_SCAN3: begin
                o_cmd.blk_step = 1'b1;
                if (i_sts.blk_at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    `BMRQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `BMRQ_ASSERT_NXT(a_accept_check, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK)

endmodule

// ===== src/block_max_range_query.sv =====
// Top level: square-root-decomposition range max store with APB config.
//
//  channel   dir   handshake          payload
//  i_req     in    valid/ready        opcode, first_index, last_index, amount
//  o_rsp     out   valid/ready        range_max, status
//  apb       in    psel/penable       paddr, pwdata -> used_length (reg 0)
//
// After reset a clearing pass zeroes the 1024-entry element memory, one entry
// per cycle, so no request is taken until the pass ends. Block maxima
// are flops and clear at once. One request is worked at a time:
//   error: check, then result; load/add: read-modify-write on the memory port;
//   query: head/tail block elements scanned, middle blocks from their maxima,
//   using the single element-memory port, one element read per cycle.
// The result sits in an output register; the next request is taken while it
// waits. A result stalled on o_rsp only holds the controller at its end.
module block_max_range_query (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bmrq_req_if.sink                        i_req,
    bmrq_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmrq_pkg::APB_AW-1:0]     paddr,
    input  logic [bmrq_pkg::APB_DW-1:0]     pwdata,
    output logic [bmrq_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import bmrq_pkg::*;

    logic [LEN_W-1:0] r_used_length;
    t_cmd             cmd;
    t_sts             sts;

    // config register: written on the APB access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_length <= USED_LENGTH_RST;
        end else if (psel && penable && pwrite && pready && (paddr == REG_USED_LENGTH)) begin
            r_used_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr == REG_USED_LENGTH) ? APB_DW'(r_used_length) : '0;

    // controller owns sequencing; datapath owns storage and arithmetic
    bmrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmrq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_used_length (r_used_length),
        .i_opcode      (i_req.opcode),
        .i_first_index (i_req.first_index),
        .i_last_index  (i_req.last_index),
        .i_amount      (i_req.amount),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_range_max   (o_rsp.range_max),
        .o_status      (o_rsp.status)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for block_max_range_query: directed, length-setting, random, stall and wide-add tests.
module tb_top;
    import bmrq_pkg::*;

    // ------------------------------------------------------------------
    // Timing and run limits
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    // Idle wait after the last result, so the controller is finished before a register write.
    localparam int SETTLE_CYCLES  = 120;
    // Watchdog bound: a clean run ends well within it even with every item a
    // full-length query under the heaviest stalls and the clearing pass after reset.
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WIDE_ADDS      = 8;

    // Opcode 3 has no meaning in the block; it must come back as an error.
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam logic            STATUS_OK  = 1'b0;
    localparam logic            STATUS_ERR = 1'b1;
    localparam logic [AMT_W-1:0] AMT_MAX   = '1;

    typedef struct packed {
        t_val range_max;
        logic status;
    } t_rmq_result;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] first_idx;
        logic [LEN_W-1:0] last_idx;
        logic [AMT_W-1:0] amount;
    } t_rmq_request;

    // ------------------------------------------------------------------
    // Clock, reset, channels, config port
    // ------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bmrq_req_if req_ch();
    bmrq_rsp_if rsp_ch();

    block_max_range_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block state, kept in acceptance order
    // ------------------------------------------------------------------
    t_val             shadow_elem    [DEPTH];
    t_val             shadow_blk_max [NBLK];
    logic [LEN_W-1:0] shadow_len;

    // Expected range results, oldest first.
    t_rmq_result pending_results[$];

    // Traffic shaping knobs, percent of cycles.
    int send_idle_pct;
    int recv_stall_pct;
    // Long receiver hold-off, counted down by the receiver process.
    int recv_hold_cycles;

    int mismatch_count;
    int results_checked;
    int items_sent;
    int length_writes;

    // ------------------------------------------------------------------
    // Predictor: applies one request to the shadow state and returns
    // the result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic t_rmq_result model_request(input logic [OP_W-1:0]  op,
                                                  input logic [LEN_W-1:0] first_idx,
                                                  input logic [LEN_W-1:0] last_idx,
                                                  input logic [AMT_W-1:0] amount);
        t_rmq_result    res;
        int             lim;
        int             s;
        int             t;
        int             bs;
        int             bt;
        logic [VAL_W:0] sum;
        t_val           v;
        t_val           best;

        res = '{range_max: '0, status: STATUS_ERR};
        lim = (int'(shadow_len) < DEPTH) ? int'(shadow_len) : DEPTH;

        // unused opcode, or start index outside 1..limit
        if (op != OP_LOAD && op != OP_ADD && op != OP_QUERY)
            return res;
        if (int'(first_idx) < 1 || int'(first_idx) > lim)
            return res;

        if (op == OP_LOAD || op == OP_ADD) begin
            s = int'(first_idx) - 1;
            if (op == OP_LOAD) begin
                v = t_val'(amount);
            end else begin
                sum = {1'b0, shadow_elem[s]} + (VAL_W+1)'(amount);
                // saturate the element at all ones
                v   = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
            end
            shadow_elem[s] = v;
            // block maximum only rises, even when a load lowers the element
            if (v > shadow_blk_max[s / BLOCK])
                shadow_blk_max[s / BLOCK] = v;
            res = '{range_max: v, status: STATUS_OK};
            return res;
        end

        // range query: end out of range or start after end is an error
        if (int'(last_idx) < 1 || int'(last_idx) > lim || first_idx > last_idx)
            return res;

        s    = int'(first_idx) - 1;
        t    = int'(last_idx) - 1;
        bs   = s / BLOCK;
        bt   = t / BLOCK;
        best = '0;
        if (bs == bt) begin
            for (int i = s; i <= t; i++)
                if (shadow_elem[i] > best) best = shadow_elem[i];
        end else begin
            for (int i = s; i <= bs * BLOCK + BLOCK - 1; i++)
                if (shadow_elem[i] > best) best = shadow_elem[i];
            for (int i = bt * BLOCK; i <= t; i++)
                if (shadow_elem[i] > best) best = shadow_elem[i];
            // whole blocks in between come from the stored maxima
            for (int i = bs + 1; i < bt; i++)
                if (shadow_blk_max[i] > best) best = shadow_blk_max[i];
        end
        res = '{range_max: best, status: STATUS_OK};
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb: mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Random request generation
    // ------------------------------------------------------------------
    // Index in 1..lim, biased toward the ends and block boundaries.
    function automatic logic [LEN_W-1:0] pick_index(input int lim);
        int k;
        case ($urandom_range(9))
            0: k = 1;
            1: k = lim;
            2: k = BLOCK * int'($urandom_range(1, NBLK));
            3: k = BLOCK * int'($urandom_range(0, NBLK - 1)) + 1;
            default: k = int'($urandom_range(1, lim));
        endcase
        if (k > lim) k = lim;
        return LEN_W'(k);
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(3))
            0, 1: return AMT_W'($urandom_range(0, 1000));
            2:    return AMT_W'($urandom);
            default: return AMT_W'($urandom) | 32'hF000_0000;
        endcase
    endfunction

    // Mostly well-formed traffic; a few percent is errors of every kind but a zero end index.
    function automatic t_rmq_request random_request();
        t_rmq_request r;
        int           lim;
        int           a;
        int           b;
        int           tmp;
        int           pick;

        lim         = (int'(shadow_len) < DEPTH) ? int'(shadow_len) : DEPTH;
        r.op        = OP_LOAD;
        r.first_idx = pick_index(lim);
        r.last_idx  = LEN_W'($urandom_range(0, 2047));   // don't care for load/add
        r.amount    = pick_amount();
        pick        = int'($urandom_range(99));

        if (pick < 6) begin
            case ($urandom_range(3))
                0: r.op = OP_UNUSED;
                1: begin
                    r.op        = OP_W'($urandom_range(0, 2));
                    r.first_idx = '0;
                end
                2: begin
                    r.op        = OP_W'($urandom_range(0, 2));
                    r.first_idx = LEN_W'($urandom_range(lim + 1, 2047));
                end
                default: begin
                    r.op = OP_QUERY;
                    if (r.first_idx > 1)
                        r.last_idx = LEN_W'($urandom_range(1, int'(r.first_idx) - 1));
                    else
                        r.last_idx = LEN_W'($urandom_range(lim + 1, 2047));
                end
            endcase
        end else if (pick < 40) begin
            r.op = OP_LOAD;
        end else if (pick < 62) begin
            r.op = OP_ADD;
        end else begin
            r.op = OP_QUERY;
            a    = int'(pick_index(lim));
            b    = int'(pick_index(lim));
            if (a > b) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            case ($urandom_range(3))
                0: begin
                    // inside one block
                    b = ((a - 1) / BLOCK) * BLOCK + BLOCK;
                    if (b > lim) b = lim;
                    b = int'($urandom_range(a, b));
                end
                1: ;  // arbitrary span
                2: begin
                    // whole blocks only, the last one cut at lim
                    a = ((a - 1) / BLOCK) * BLOCK + 1;
                    b = ((b - 1) / BLOCK) * BLOCK + BLOCK;
                    if (b > lim) b = lim;
                end
                default: begin
                    a = 1;
                    b = lim;
                end
            endcase
            r.first_idx = LEN_W'(a);
            r.last_idx  = LEN_W'(b);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: optional idle gap, then hold valid until accepted.
    // valid stays high after acceptance so back-to-back items don't glitch.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [OP_W-1:0]  op,
                           input logic [LEN_W-1:0] first_idx,
                           input logic [LEN_W-1:0] last_idx,
                           input logic [AMT_W-1:0] amount);
        while (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.first_index <= first_idx;
        req_ch.last_index  <= last_idx;
        req_ch.amount      <= amount;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(model_request(op, first_idx, last_idx, amount));
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the controller settle.
    task automatic wait_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, access cycle, then bus released.
    task automatic apb_transfer(input logic is_write, input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= REG_USED_LENGTH;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called with the block idle; reads the value back as well.
    task automatic set_used_length(input logic [LEN_W-1:0] len);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_transfer(1'b1, APB_DW'(len), rd);
        shadow_len = len;
        length_writes++;
        apb_transfer(1'b0, '0, rd);
        if (rd[LEN_W-1:0] !== len)
            note_mismatch("used_length readback", 64'(len), 64'(rd[LEN_W-1:0]));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, every opcode, lowering loads and every error kind.
    task automatic test_directed();
        send_op(OP_LOAD,  11'd1,    11'd0,    AMT_MAX);
        send_op(OP_LOAD,  11'd1024, 11'd2047, 32'd0);
        send_op(OP_ADD,   11'd1024, 11'd0,    AMT_MAX);
        send_op(OP_ADD,   11'd1024, 11'd0,    32'd0);
        send_op(OP_LOAD,  11'd40,   11'd0,    32'd1000);
        // lower the element; block 1 keeps 1000 as its maximum
        send_op(OP_LOAD,  11'd40,   11'd0,    32'd10);
        send_op(OP_QUERY, 11'd33,   11'd64,   32'd0);   // one block, scanned: 10
        send_op(OP_QUERY, 11'd2,    11'd96,   32'd0);   // block 1 whole: stale 1000
        send_op(OP_QUERY, 11'd1,    11'd1024, 32'd0);
        send_op(OP_QUERY, 11'd1,    11'd1,    32'd0);
        send_op(OP_QUERY, 11'd1024, 11'd1024, 32'd0);
        send_op(OP_QUERY, 11'd30,   11'd70,   32'd0);
        send_op(OP_ADD,   11'd2,    11'd0,    32'd0);
        // errors: none of these may change state
        send_op(OP_LOAD,  11'd0,    11'd0,    32'd5);
        send_op(OP_ADD,   11'd1025, 11'd0,    32'd5);
        send_op(OP_QUERY, 11'd2047, 11'd2047, 32'd0);
        send_op(OP_QUERY, 11'd10,   11'd5,    32'd0);
        send_op(OP_QUERY, 11'd5,    11'd0,    32'd0);
        send_op(OP_QUERY, 11'd5,    11'd1025, 32'd0);
        send_op(OP_UNUSED, 11'd5,   11'd5,    32'd5);
        send_op(OP_QUERY, 11'd1,    11'd1024, 32'd0);
    endtask

    // Shortest and full length, plus one just past a block boundary.
    task automatic test_length_settings();
        set_used_length(11'd1);
        send_op(OP_LOAD,  11'd1,  11'd0,  32'd7);
        send_op(OP_LOAD,  11'd2,  11'd0,  32'd7);
        send_op(OP_QUERY, 11'd1,  11'd1,  32'd0);
        send_op(OP_QUERY, 11'd1,  11'd2,  32'd0);
        send_op(OP_ADD,   11'd1,  11'd0,  32'd3);
        set_used_length(11'd33);
        send_op(OP_QUERY, 11'd1,  11'd33, 32'd0);
        send_op(OP_LOAD,  11'd33, 11'd0,  32'd99);
        send_op(OP_ADD,   11'd34, 11'd0,  32'd1);
        send_op(OP_QUERY, 11'd32, 11'd33, 32'd0);
        set_used_length(USED_LENGTH_RST);
        send_op(OP_QUERY, 11'd1,  11'd1024, 32'd0);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct, input logic [LEN_W-1:0] len);
        t_rmq_request r;
        set_used_length(len);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            r = random_request();
            send_op(r.op, r.first_idx, r.last_idx, r.amount);
        end
        wait_idle();
    endtask

    // Receiver holds off long enough that the output register and the
    // controller fill up and the request side has to stall.
    task automatic test_backpressure();
        t_rmq_request r;
        wait_idle();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = HOLD_OFF_LEN;
        repeat (16) begin
            r = random_request();
            send_op(r.op, r.first_idx, r.last_idx, r.amount);
        end
        wait_idle();
    endtask

    // Repeated maximal adds carry the element well past 32 bits.
    task automatic test_wide_adds();
        set_used_length(USED_LENGTH_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(OP_LOAD, 11'd1024, 11'd0, AMT_MAX);
        repeat (WIDE_ADDS) send_op(OP_ADD, 11'd1024, 11'd0, AMT_MAX);
        send_op(OP_QUERY, 11'd1000, 11'd1024, 32'd0);
        send_op(OP_QUERY, 11'd1,    11'd1024, 32'd0);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Receiver: ready changes on the falling edge; a pending hold-off
    // wins over the random stall.
    // ------------------------------------------------------------------
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles > 0) begin
                rsp_ch.ready     <= 1'b0;
                recv_hold_cycles = recv_hold_cycles - 1;
            end else if (recv_stall_pct > 0 && int'($urandom_range(99)) < recv_stall_pct) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_checker
        t_rmq_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 64'd0, 64'(rsp_ch.range_max));
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.range_max !== want.range_max)
                    note_mismatch("range_max", 64'(want.range_max), 64'(rsp_ch.range_max));
                if (rsp_ch.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: timeout with %0d results outstanding", pending_results.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_LOAD;
        req_ch.first_index = '0;
        req_ch.last_index  = '0;
        req_ch.amount      = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = REG_USED_LENGTH;
        pwdata             = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        recv_hold_cycles   = 0;
        mismatch_count     = 0;
        results_checked    = 0;
        items_sent         = 0;
        length_writes      = 0;
        shadow_len         = USED_LENGTH_RST;
        for (int i = 0; i < DEPTH; i++) shadow_elem[i] = '0;
        for (int i = 0; i < NBLK; i++) shadow_blk_max[i] = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass keeps ready low; send_op just waits.
        test_directed();
        test_length_settings();
        test_random_traffic(100, 0,  0,  USED_LENGTH_RST);
        test_random_traffic(100, 66, 0,  LEN_W'($urandom_range(100, 1023)));
        test_random_traffic(100, 0,  66, USED_LENGTH_RST);
        test_random_traffic(100, 26, 26, 11'd65);
        test_backpressure();
        test_wide_adds();

        $display("tb: %0d transactions sent, %0d results checked, %0d length writes",
                 items_sent, results_checked, length_writes);
        $display("tb: covered load/add/query, all error kinds, stalls and wide adds");
        if (pending_results.size() != 0)
            $display("tb: %0d expected results never arrived", pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
